FILE: rtl/srgbxy_pkg.sv
// ---------------------------------------------------------------------------
// srgbxy_pkg: shared constants and table builders
// sRGB to xy converter constants, matrix and linearization curve generator
// ---------------------------------------------------------------------------
package srgbxy_pkg;

  localparam int unsigned LIN_FRAC_DEF = 16;
  localparam int unsigned QUOT_BITS    = 16;
  localparam int unsigned CFG_IDX_W    = 8;

  localparam logic [15:0] DEF_X_RST = 16'd20492;
  localparam logic [15:0] DEF_Y_RST = 16'd21561;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEFAULT_X = 8'd0,
    REG_DEFAULT_Y = 8'd1
  } cfg_reg_t;

  // srgb (d65) to xyz, q0.16, row major
  localparam logic [15:0] MAT [9] = '{
    16'd27031, 16'd23434, 16'd11825,
    16'd13938, 16'd46868, 16'd4730,
    16'd1267,  16'd7811,  16'd62279
  };

  // gamma curve in q0.30, evaluated at elaboration only
  function automatic longint unsigned curve30(int unsigned v);
    longint unsigned one30;
    longint unsigned b;
    longint unsigned q;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    longint unsigned p;
    one30 = 64'd1 << 30;
    if (v <= 10) begin
      return (longint'(v) * 10 * one30 + 16473) / 32946;
    end
    b  = ((longint'(v) * 1000 + 14025) * one30 + 134512) / 269025;
    q  = (b * b + (one30 >> 1)) >> 30;
    lo = 0;
    hi = one30;
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      p = mid;
      for (int k = 0; k < 4; k++) begin
        p = (p * mid) >> 30;
      end
      if (p <= q) begin
        lo = mid;
      end else begin
        hi = mid - 1;
      end
    end
    return (q * lo + (one30 >> 1)) >> 30;
  endfunction

  // one table entry in q0.f, saturated below 1.0
  function automatic int unsigned lin_entry(int unsigned v, int unsigned f);
    longint unsigned l;
    longint unsigned maxv;
    int unsigned     sh;
    sh   = 30 - f;
    maxv = (64'd1 << f) - 1;
    l    = (curve30(v) + (64'd1 << (sh - 1))) >> sh;
    if (l > maxv) begin
      l = maxv;
    end
    return int'(l);
  endfunction

endpackage

FILE: rtl/srgbxy_front.sv
// ---------------------------------------------------------------------------
// srgbxy_front: linearize, matrix and dividend setup
// Four register stages: table lookup, products, row sums, sum and dividends
// ---------------------------------------------------------------------------
module srgbxy_front #(
  parameter int unsigned LINEAR_FRAC_BITS = srgbxy_pkg::LIN_FRAC_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [7:0]                   red,
  input  logic [7:0]                   green,
  input  logic [7:0]                   blue,
  output logic                         out_valid,
  output logic [LINEAR_FRAC_BITS+17:0] sum,
  output logic [LINEAR_FRAC_BITS+31:0] num_x,
  output logic [LINEAR_FRAC_BITS+31:0] num_y,
  output logic                         black
);
  import srgbxy_pkg::*;

  localparam int unsigned F  = LINEAR_FRAC_BITS;
  localparam int unsigned PW = F + 16;
  localparam int unsigned SW = F + 18;
  localparam int unsigned NW = F + 32;

  logic [F-1:0] rom [256];

  for (genvar g = 0; g < 256; g++) begin : g_rom
    localparam logic [F-1:0] ENTRY = F'(lin_entry(g, F));
    assign rom[g] = ENTRY;
  end

  logic [F-1:0]  lin_r  [3];
  logic [PW-1:0] prod_r [9];
  logic [SW-1:0] xyz_r  [3];
  logic [SW-1:0] sum_r;
  logic [NW-1:0] nx_r;
  logic [NW-1:0] ny_r;
  logic          black_r;
  logic [3:0]    vld_r;

  logic [SW-1:0] sum_nxt;

  assign sum_nxt = xyz_r[0] + xyz_r[1] + xyz_r[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lin_r[0] <= rom[red];
      lin_r[1] <= rom[green];
      lin_r[2] <= rom[blue];
      for (int i = 0; i < 9; i++) begin
        prod_r[i] <= PW'(MAT[i]) * PW'(lin_r[i % 3]);
      end
      for (int r = 0; r < 3; r++) begin
        xyz_r[r] <= SW'(prod_r[3*r]) + SW'(prod_r[3*r+1]) + SW'(prod_r[3*r+2]);
      end
      sum_r   <= sum_nxt;
      // times 65535 as shift and subtract
      nx_r    <= (NW'(xyz_r[0]) << 16) - NW'(xyz_r[0]);
      ny_r    <= (NW'(xyz_r[1]) << 16) - NW'(xyz_r[1]);
      black_r <= (sum_nxt == '0);
    end
  end

  assign out_valid = vld_r[3];
  assign sum       = sum_r;
  assign num_x     = nx_r;
  assign num_y     = ny_r;
  assign black     = black_r;

endmodule

FILE: rtl/srgbxy_div_cell.sv
// ---------------------------------------------------------------------------
// srgbxy_div_cell: one quotient bit of the x and y division
// Restoring compare and subtract against the divisor shifted by BIT_POS
// ---------------------------------------------------------------------------
module srgbxy_div_cell #(
  parameter int unsigned LINEAR_FRAC_BITS = srgbxy_pkg::LIN_FRAC_DEF,
  parameter int unsigned BIT_POS          = 0
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [LINEAR_FRAC_BITS+17:0] in_sum,
  input  logic [LINEAR_FRAC_BITS+31:0] in_rem_x,
  input  logic [LINEAR_FRAC_BITS+31:0] in_rem_y,
  input  logic [15:0]                  in_q_x,
  input  logic [15:0]                  in_q_y,
  input  logic                         in_black,
  output logic                         out_valid,
  output logic [LINEAR_FRAC_BITS+17:0] out_sum,
  output logic [LINEAR_FRAC_BITS+31:0] out_rem_x,
  output logic [LINEAR_FRAC_BITS+31:0] out_rem_y,
  output logic [15:0]                  out_q_x,
  output logic [15:0]                  out_q_y,
  output logic                         out_black
);
  localparam int unsigned NW = LINEAR_FRAC_BITS + 32;
  localparam int unsigned CW = NW + 2;

  logic [CW-1:0] dsh;
  logic          ge_x;
  logic          ge_y;

  logic                         vld_r;
  logic [LINEAR_FRAC_BITS+17:0] sum_r;
  logic [NW-1:0]                rx_r;
  logic [NW-1:0]                ry_r;
  logic [15:0]                  qx_r;
  logic [15:0]                  qy_r;
  logic                         black_r;

  assign dsh  = CW'(in_sum) << BIT_POS;
  assign ge_x = CW'(in_rem_x) >= dsh;
  assign ge_y = CW'(in_rem_y) >= dsh;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum_r   <= in_sum;
      rx_r    <= ge_x ? in_rem_x - dsh[NW-1:0] : in_rem_x;
      ry_r    <= ge_y ? in_rem_y - dsh[NW-1:0] : in_rem_y;
      qx_r    <= {in_q_x[14:0], ge_x};
      qy_r    <= {in_q_y[14:0], ge_y};
      black_r <= in_black;
    end
  end

  assign out_valid = vld_r;
  assign out_sum   = sum_r;
  assign out_rem_x = rx_r;
  assign out_rem_y = ry_r;
  assign out_q_x   = qx_r;
  assign out_q_y   = qy_r;
  assign out_black = black_r;

endmodule

FILE: rtl/srgbxy_obuf.sv
// ---------------------------------------------------------------------------
// srgbxy_obuf: two-entry output queue
// Separates the pipeline from output back pressure, room flag is registered
// ---------------------------------------------------------------------------
module srgbxy_obuf (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  logic [32:0] push_data,
  output logic        room,
  output logic        pop_valid,
  input  logic        pop_ready,
  output logic [32:0] pop_data
);
  logic [32:0] mem_r [2];
  logic [1:0]  cnt_r;
  logic [1:0]  cnt_nxt;
  logic        wp_r;
  logic        rp_r;
  logic        pop;

  assign pop     = pop_valid && pop_ready;
  assign cnt_nxt = cnt_r + 2'(push) - 2'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wp_r <= !wp_r;
      end
      if (pop) begin
        rp_r <= !rp_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
  end

  assign room      = (cnt_r != 2'd2);
  assign pop_valid = (cnt_r != 2'd0);
  assign pop_data  = mem_r[rp_r];

endmodule

FILE: rtl/srgb_to_cie_xy.sv
// ---------------------------------------------------------------------------
// srgb_to_cie_xy: sRGB pixel to CIE 1931 xy chromaticity
// Table linearization, 3x3 matrix, and a bit-per-cell divider chain
// ---------------------------------------------------------------------------
// One pixel is taken per clock while in_tready is high, and one result is
// given per pixel, in order. The path from input transfer to output valid
// runs through four front stages (gamma table, matrix products, row sums, sum
// and dividends), sixteen divider cells that each settle one quotient bit of
// x and y, and a two-entry output
// queue. in_tready comes from a register: it drops only when the output queue
// is full, and then the whole pipeline holds. A black pixel (all channels 0)
// gives the default_x/default_y registers with was_black set; those registers
// are read as the result enters the output queue.
module srgb_to_cie_xy #(
  parameter int unsigned LINEAR_FRAC_BITS = srgbxy_pkg::LIN_FRAC_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input pixel stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [23:0]                       in_tdata,   // red, green, blue
  // result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [31:0]                       out_tdata,  // chroma_x, chroma_y
  output logic                              out_tuser,  // was_black
  // register writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [srgbxy_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [15:0]                       cfg_data
);
  import srgbxy_pkg::*;

  localparam int unsigned F  = LINEAR_FRAC_BITS;
  localparam int unsigned SW = F + 18;
  localparam int unsigned NW = F + 32;
  localparam int unsigned NC = QUOT_BITS;

  logic en;

  // default white point registers
  logic [15:0] def_x_r;
  logic [15:0] def_y_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      def_x_r <= DEF_X_RST;
      def_y_r <= DEF_Y_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_DEFAULT_X: def_x_r <= cfg_data;
        REG_DEFAULT_Y: def_y_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // front end
  logic          f_vld;
  logic [SW-1:0] f_sum;
  logic [NW-1:0] f_nx;
  logic [NW-1:0] f_ny;
  logic          f_black;

  srgbxy_front #(.LINEAR_FRAC_BITS(F)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_tvalid && in_tready),
    .red       (in_tdata[7:0]),
    .green     (in_tdata[15:8]),
    .blue      (in_tdata[23:16]),
    .out_valid (f_vld),
    .sum       (f_sum),
    .num_x     (f_nx),
    .num_y     (f_ny),
    .black     (f_black)
  );

  // divider chain, msb first; link 0 is the chain input
  logic          c_vld   [NC+1];
  logic [SW-1:0] c_sum   [NC+1];
  logic [NW-1:0] c_rx    [NC+1];
  logic [NW-1:0] c_ry    [NC+1];
  logic [15:0]   c_qx    [NC+1];
  logic [15:0]   c_qy    [NC+1];
  logic          c_black [NC+1];

  assign c_vld[0]   = f_vld;
  assign c_sum[0]   = f_sum;
  assign c_rx[0]    = f_nx;
  assign c_ry[0]    = f_ny;
  assign c_qx[0]    = '0;
  assign c_qy[0]    = '0;
  assign c_black[0] = f_black;

  for (genvar k = 0; k < NC; k++) begin : g_cell
    srgbxy_div_cell #(
      .LINEAR_FRAC_BITS (F),
      .BIT_POS          (NC - 1 - k)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (c_vld[k]),
      .in_sum    (c_sum[k]),
      .in_rem_x  (c_rx[k]),
      .in_rem_y  (c_ry[k]),
      .in_q_x    (c_qx[k]),
      .in_q_y    (c_qy[k]),
      .in_black  (c_black[k]),
      .out_valid (c_vld[k+1]),
      .out_sum   (c_sum[k+1]),
      .out_rem_x (c_rx[k+1]),
      .out_rem_y (c_ry[k+1]),
      .out_q_x   (c_qx[k+1]),
      .out_q_y   (c_qy[k+1]),
      .out_black (c_black[k+1])
    );
  end

  // result select, default point for black
  logic [32:0] res;
  logic [32:0] head;

  assign res = c_black[NC] ? {1'b1, def_y_r, def_x_r}
                           : {1'b0, c_qy[NC], c_qx[NC]};

  srgbxy_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (en && c_vld[NC]),
    .push_data (res),
    .room      (en),
    .pop_valid (out_tvalid),
    .pop_ready (out_tready),
    .pop_data  (head)
  );

  assign in_tready = en;
  assign out_tdata = head[31:0];
  assign out_tuser = head[32];

endmodule

FILE: rtl/srgbxy_chk.sv
// ---------------------------------------------------------------------------
// srgbxy_chk: port-level checks for srgb_to_cie_xy
// Output hold under stall, chromaticity bound, stall only with data pending
// ---------------------------------------------------------------------------
module srgbxy_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tuser
);

  // a stalled result keeps valid and payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("output changed while stalled");

  // x + y never exceeds one for a computed result
  a_xy_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |->
      (17'(out_tdata[15:0]) + 17'(out_tdata[31:16])) <= 17'd65535)
    else $error("x plus y above one");

  // input stalls only when results are waiting
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with empty output");

endmodule

bind srgb_to_cie_xy srgbxy_chk u_chk (.*);
